### design/ptsa_pkg.sv
// shared constants and the arctangent table for the twirl source address block
package ptsa_pkg;

  localparam int CORDIC_STEPS = 28;
  localparam int SQRT_STEPS   = 21;

  typedef enum logic [2:0] {
    CFG_WIDTH  = 3'd0,
    CFG_HEIGHT = 3'd1,
    CFG_ANGLE  = 3'd2,
    CFG_RADIUS = 3'd3
  } cfg_idx_t;

  localparam logic [31:0] TURN_HALF    = 32'h8000_0000;
  localparam logic [31:0] TURN_QUARTER = 32'h4000_0000;
  localparam logic [31:0] TURN_3QUART  = 32'hC000_0000;

  // atan(2^-i) as a fraction of a turn, q0.32
  function automatic logic [31:0] atan_turn(input logic [4:0] i);
    logic [31:0] a;
    case (i)
      5'd0:    a = 32'h20000000;
      5'd1:    a = 32'h12E4051E;
      5'd2:    a = 32'h09FB385B;
      5'd3:    a = 32'h051111D4;
      5'd4:    a = 32'h028B0D43;
      5'd5:    a = 32'h0145D7E1;
      5'd6:    a = 32'h00A2F61E;
      5'd7:    a = 32'h00517C55;
      5'd8:    a = 32'h0028BE53;
      5'd9:    a = 32'h00145F2F;
      5'd10:   a = 32'h000A2F98;
      5'd11:   a = 32'h000517CC;
      5'd12:   a = 32'h00028BE6;
      5'd13:   a = 32'h000145F3;
      5'd14:   a = 32'h0000A2FA;
      5'd15:   a = 32'h0000517D;
      5'd16:   a = 32'h000028BE;
      5'd17:   a = 32'h0000145F;
      5'd18:   a = 32'h00000A30;
      5'd19:   a = 32'h00000518;
      5'd20:   a = 32'h0000028C;
      5'd21:   a = 32'h00000146;
      5'd22:   a = 32'h000000A3;
      5'd23:   a = 32'h00000051;
      5'd24:   a = 32'h00000029;
      5'd25:   a = 32'h00000014;
      5'd26:   a = 32'h0000000A;
      5'd27:   a = 32'h00000005;
      default: a = 32'h0;
    endcase
    return a;
  endfunction

endpackage

### design/polar_twirl_source_address.sv
// top level: pipelined source address generator for the polar twirl remap
// One item enters per clock while the pipeline advances, and passes 32 register stages (input
// stage, square and cordic setup, 28 cordic steps that also carry the 21 square root steps, two
// multiply and range stages) before its result is offered. The depth is set by the 28-step
// cordic chain, one step per register stage.
// The whole pipeline moves together: it advances whenever the output register is empty or
// being taken, so with a ready consumer the block sustains one item per clock. Config writes
// take effect at once and belong between items.
module polar_twirl_source_address #(
  parameter int PHASE_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [11:0] in_out_x,
  input  logic [11:0] in_out_y,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [11:0] out_dest_x,
  output logic [11:0] out_dest_y,
  output logic [11:0] out_src_x,
  output logic [11:0] out_src_y,
  output logic        out_in_range,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [27:0] cfg_data
);
  import ptsa_pkg::*;

  localparam int FRAC  = 16 + PHASE_BITS;
  localparam int PW    = 28 + PHASE_BITS;   // angle product width
  localparam int DW    = PW + 1;            // signed difference width
  localparam int NS    = CORDIC_STEPS;

  // configuration registers
  logic [11:0] width_r, height_r;
  logic [27:0] ang_scale_r;
  logic [17:0] rad_scale_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r     <= 12'd640;
      height_r    <= 12'd480;
      ang_scale_r <= 28'd41963946;
      rad_scale_r <= 18'd78643;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_WIDTH:  width_r     <= cfg_data[11:0];
        CFG_HEIGHT: height_r    <= cfg_data[11:0];
        CFG_ANGLE:  ang_scale_r <= cfg_data;
        CFG_RADIUS: rad_scale_r <= cfg_data[17:0];
        default:    ;
      endcase
    end
  end

  // global pipeline advance
  logic adv;
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  // stage a: centre offsets, trunc((2*o - dim)/2)
  logic               a_vld_r;
  logic [11:0]        a_ox_r, a_oy_r;
  logic signed [12:0] a_cx_r, a_cy_r;
  logic signed [13:0] tx, ty;
  logic signed [12:0] cx_nxt, cy_nxt;

  always_comb begin
    tx     = $signed({1'b0, in_out_x, 1'b0}) - $signed({2'b00, width_r});
    ty     = $signed({1'b0, in_out_y, 1'b0}) - $signed({2'b00, height_r});
    cx_nxt = 13'((tx + $signed({13'd0, tx[13]})) >>> 1);
    cy_nxt = 13'((ty + $signed({13'd0, ty[13]})) >>> 1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) a_vld_r <= 1'b0;
    else if (adv) a_vld_r <= in_valid;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      a_ox_r <= in_out_x;
      a_oy_r <= in_out_y;
      a_cx_r <= cx_nxt;
      a_cy_r <= cy_nxt;
    end
  end

  // cordic / square root chain, index 0 is the setup stage
  logic               c_vld_r  [0:NS];
  logic [11:0]        c_ox_r   [0:NS];
  logic [11:0]        c_oy_r   [0:NS];
  logic signed [32:0] c_x_r    [0:NS];
  logic signed [32:0] c_y_r    [0:NS];
  logic [31:0]        c_acc_r  [0:NS];
  logic               c_axis_r [0:NS];   // phase settled exactly on an axis
  logic [40:0]        s_v_r    [0:NS];
  logic [40:0]        s_res_r  [0:NS];

  // setup: sum of squares, axis cases, half-turn fold for the left half plane
  logic signed [25:0] sqx, sqy;
  logic [24:0]        sqsum;
  logic               axis_nxt;
  logic [31:0]        acc0_nxt;
  logic signed [32:0] x0_nxt, y0_nxt;

  always_comb begin
    sqx      = a_cx_r * a_cx_r;
    sqy      = a_cy_r * a_cy_r;
    sqsum    = 25'(sqx) + 25'(sqy);
    axis_nxt = (a_cy_r == '0) || (a_cx_r == '0);
    x0_nxt   = 33'(a_cx_r) <<< 16;
    y0_nxt   = 33'(a_cy_r) <<< 16;
    acc0_nxt = '0;
    if (a_cy_r == '0) begin
      acc0_nxt = a_cx_r[12] ? TURN_HALF : '0;
    end else if (a_cx_r == '0) begin
      acc0_nxt = a_cy_r[12] ? TURN_3QUART : TURN_QUARTER;
    end else if (a_cx_r[12]) begin
      x0_nxt   = -x0_nxt;
      y0_nxt   = -y0_nxt;
      acc0_nxt = TURN_HALF;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) c_vld_r[0] <= 1'b0;
    else if (adv) c_vld_r[0] <= a_vld_r;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      c_ox_r[0]   <= a_ox_r;
      c_oy_r[0]   <= a_oy_r;
      c_x_r[0]    <= x0_nxt;
      c_y_r[0]    <= y0_nxt;
      c_acc_r[0]  <= acc0_nxt;
      c_axis_r[0] <= axis_nxt;
      s_v_r[0]    <= {sqsum, 16'd0};
      s_res_r[0]  <= '0;
    end
  end

  for (genvar j = 0; j < NS; j++) begin : g_step
    logic signed [32:0] xs, ys;
    logic [40:0]        trial, v_nxt, res_nxt;

    always_comb begin
      xs      = c_x_r[j] >>> j;
      ys      = c_y_r[j] >>> j;
      v_nxt   = s_v_r[j];
      res_nxt = s_res_r[j];
      trial   = '0;
      if (j < SQRT_STEPS) begin
        // square root digit: bit weight 4^(20-j)
        trial = s_res_r[j] + (41'd1 << (2 * (SQRT_STEPS - 1 - j)));
        if (s_v_r[j] >= trial) begin
          v_nxt   = s_v_r[j] - trial;
          res_nxt = (s_res_r[j] >> 1) + (41'd1 << (2 * (SQRT_STEPS - 1 - j)));
        end else begin
          res_nxt = s_res_r[j] >> 1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) c_vld_r[j+1] <= 1'b0;
      else if (adv) c_vld_r[j+1] <= c_vld_r[j];
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        c_ox_r[j+1]   <= c_ox_r[j];
        c_oy_r[j+1]   <= c_oy_r[j];
        c_axis_r[j+1] <= c_axis_r[j];
        s_v_r[j+1]    <= v_nxt;
        s_res_r[j+1]  <= res_nxt;
        if (c_axis_r[j]) begin
          c_x_r[j+1]   <= c_x_r[j];
          c_y_r[j+1]   <= c_y_r[j];
          c_acc_r[j+1] <= c_acc_r[j];
        end else if (!c_y_r[j][32]) begin
          c_x_r[j+1]   <= c_x_r[j] + ys;
          c_y_r[j+1]   <= c_y_r[j] - xs;
          c_acc_r[j+1] <= c_acc_r[j] + atan_turn(5'(j));
        end else begin
          c_x_r[j+1]   <= c_x_r[j] - ys;
          c_y_r[j+1]   <= c_y_r[j] + xs;
          c_acc_r[j+1] <= c_acc_r[j] - atan_turn(5'(j));
        end
      end
    end
  end

  // stage d: scale phase and radius
  logic                  d_vld_r;
  logic [11:0]           d_ox_r, d_oy_r;
  logic [PW-1:0]         d_aprod_r;
  logic [37:0]           d_rprod_r;
  logic [PHASE_BITS-1:0] phase;

  assign phase = c_acc_r[NS][31 -: PHASE_BITS];

  always_ff @(posedge clk) begin
    if (!rst_n) d_vld_r <= 1'b0;
    else if (adv) d_vld_r <= c_vld_r[NS];
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      d_ox_r    <= c_ox_r[NS];
      d_oy_r    <= c_oy_r[NS];
      d_aprod_r <= PW'(ang_scale_r * phase);
      d_rprod_r <= rad_scale_r * s_res_r[NS][20:0];
    end
  end

  // stage e: column from width minus scaled phase, range checks, output register
  logic signed [DW-1:0] diff;
  logic                 okx, ok;
  logic [11:0]          sx;
  logic [13:0]          sy;

  always_comb begin
    diff = $signed({1'b0, width_r, {FRAC{1'b0}}}) - $signed({1'b0, d_aprod_r});
    if (!diff[DW-1]) begin
      sx  = diff[FRAC +: 12];
      okx = 1'b1;
    end else begin
      // a column strictly inside (-1,0) truncates to zero, -1 itself is out
      sx  = '0;
      okx = (&diff[DW-1:FRAC]) && (|diff[FRAC-1:0]);
    end
    sy = d_rprod_r[37:24];
    ok = okx && (sx < width_r) && (sy < {2'b00, height_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid <= 1'b0;
    else if (adv) out_valid <= d_vld_r;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      out_dest_x   <= d_ox_r;
      out_dest_y   <= d_oy_r;
      out_src_x    <= ok ? sx : '0;
      out_src_y    <= ok ? sy[11:0] : '0;
      out_in_range <= ok;
    end
  end

endmodule

### design/ptsa_checker.sv
// port-level checks for the twirl source address block
module ptsa_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [11:0] out_dest_x,
  input logic [11:0] out_src_x,
  input logic [11:0] out_src_y,
  input logic        out_in_range
);

  // a black pixel carries a zero source address
  a_black_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_in_range |-> out_src_x == 12'd0 && out_src_y == 12'd0)
    else $error("out of range item with nonzero source");

  // no result right after reset
  a_reset_empty: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid)
    else $error("result valid after reset");

  // a stalled result is held
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_dest_x) && $stable(out_src_x))
    else $error("stalled result changed");

  // input is taken whenever the output side is free
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

endmodule

bind polar_twirl_source_address ptsa_checker u_ptsa_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_valid),
  .in_ready     (in_ready),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .out_dest_x   (out_dest_x),
  .out_src_x    (out_src_x),
  .out_src_y    (out_src_y),
  .out_in_range (out_in_range)
);

### tb/polar_twirl_source_address_tb.sv
// testbench for the polar twirl source address generator
`timescale 1ns / 1ps

module polar_twirl_source_address_tb;
  import ptsa_pkg::*;

  // index past the register list, must be ignored by the block
  localparam logic [2:0] CFG_UNUSED = 3'd5;
  localparam int RUN_LIMIT   = 400000;
  localparam int DRAIN_WAIT  = 40;
  localparam int PHASE_ITEMS = 170;
  localparam int HOLD_AT     = 150;
  localparam int HOLD_CYCLES = 300;

  typedef struct packed {
    logic [11:0] dest_x;
    logic [11:0] dest_y;
    logic [11:0] src_x;
    logic [11:0] src_y;
    logic        in_range;
  } remap_t;

  typedef struct packed {
    logic [11:0] x;
    logic [11:0] y;
    logic        typed;
    remap_t      exp;
  } dir_row_t;

  // own copy of the arctangent steps, fraction of a turn
  localparam logic [31:0] ATAN_STEP [28] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
    32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
    32'h00000014, 32'h0000000A, 32'h00000005
  };

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [11:0] in_out_x;
  logic [11:0] in_out_y;
  logic        out_valid;
  logic        out_ready;
  logic [11:0] out_dest_x;
  logic [11:0] out_dest_y;
  logic [11:0] out_src_x;
  logic [11:0] out_src_y;
  logic        out_in_range;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [27:0] cfg_data;

  polar_twirl_source_address u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_out_x    (in_out_x),
    .in_out_y    (in_out_y),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_dest_x  (out_dest_x),
    .out_dest_y  (out_dest_y),
    .out_src_x   (out_src_x),
    .out_src_y   (out_src_y),
    .out_in_range(out_in_range),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  // register shadow used by the predictor
  logic [11:0] img_w, img_h;
  logic [27:0] ang_scale;
  logic [17:0] rad_scale;

  remap_t pending_q[$];
  int     errors;
  int     cycles;
  int     items_sent;
  int     results_seen;
  int     tx_idle_pct, rx_idle_pct;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // expected source address of one output pixel under the current registers
  function automatic remap_t twirl_source(logic [11:0] ox, logic [11:0] oy);
    longint lx, ly, w, h, cx, cy, x, y, nx, diff, sx;
    longint unsigned phase, prod, v, root, bitv, sy;
    logic [31:0] acc;
    bit ok_x;
    remap_t r;
    lx = ox;
    ly = oy;
    w = img_w;
    h = img_h;
    // signed division truncates toward zero
    cx = (2 * lx - w) / 2;
    cy = (2 * ly - h) / 2;
    acc = '0;
    if (cy == 0) begin
      acc = (cx >= 0) ? 32'h0 : TURN_HALF;
    end else if (cx == 0) begin
      acc = (cy > 0) ? TURN_QUARTER : TURN_3QUART;
    end else begin
      x = cx * 65536;
      y = cy * 65536;
      if (x < 0) begin
        x = -x;
        y = -y;
        acc = TURN_HALF;
      end
      // vectoring rotation, arithmetic shift is a floor shift
      for (int i = 0; i < 28; i++) begin
        if (y >= 0) begin
          nx = x + (y >>> i);
          y = y - (x >>> i);
          acc = acc + ATAN_STEP[i];
        end else begin
          nx = x - (y >>> i);
          y = y + (x >>> i);
          acc = acc - ATAN_STEP[i];
        end
        x = nx;
      end
    end
    phase = acc >> 16;
    prod = longint'(ang_scale) * phase;
    diff = (w <<< 32) - longint'(prod);
    // exact integer square root of the radius with 8 fraction bits
    v = longint'(cx * cx + cy * cy) << 16;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= root + bitv) begin
        v = v - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    sy = (longint'(rad_scale) * root) >> 24;
    if (diff >= 0) begin
      sx = diff >>> 32;
      ok_x = 1'b1;
    end else if (-diff < (64'sd1 <<< 32)) begin
      sx = 0;
      ok_x = 1'b1;
    end else begin
      sx = 0;
      ok_x = 1'b0;
    end
    r.dest_x = ox;
    r.dest_y = oy;
    r.in_range = ok_x && sx < w && sx < 4096 && sy < h && sy < 4096;
    r.src_x = r.in_range ? sx[11:0] : 12'd0;
    r.src_y = r.in_range ? sy[11:0] : 12'd0;
    return r;
  endfunction

  // directed rows, typed results only where obvious
  dir_row_t dir_rows [12] = '{
    '{12'd320,  12'd240,  1'b1, '{12'd320, 12'd240, 12'd0, 12'd0, 1'b0}}, // centre, phase zero
    '{12'd400,  12'd240,  1'b1, '{12'd400, 12'd240, 12'd0, 12'd0, 1'b0}}, // positive x axis
    '{12'd4095, 12'd4095, 1'b1, '{12'd4095, 12'd4095, 12'd0, 12'd0, 1'b0}}, // far corner
    '{12'd4095, 12'd240,  1'b1, '{12'd4095, 12'd240, 12'd0, 12'd0, 1'b0}},
    '{12'd0,    12'd0,    1'b0, '0},
    '{12'd4095, 12'd0,    1'b0, '0},
    '{12'd0,    12'd4095, 1'b0, '0},
    '{12'd200,  12'd240,  1'b0, '0}, // negative x axis
    '{12'd320,  12'd300,  1'b0, '0}, // positive y axis
    '{12'd320,  12'd100,  1'b0, '0}, // negative y axis
    '{12'd400,  12'd239,  1'b0, '0}, // phase just under a full turn
    '{12'd639,  12'd479,  1'b0, '0}
  };

  task automatic wr_cfg(logic [2:0] idx, logic [27:0] d);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = d;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      CFG_WIDTH:  img_w = d[11:0];
      CFG_HEIGHT: img_h = d[11:0];
      CFG_ANGLE:  ang_scale = d;
      CFG_RADIUS: rad_scale = d[17:0];
      default: ;
    endcase
  endtask

  // offer one item, keep valid high until accepted
  task automatic send_pixel(logic [11:0] x, logic [11:0] y, bit typed, remap_t typed_exp);
    @(negedge clk);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_out_x = x;
    in_out_y = y;
    do @(posedge clk); while (!in_ready);
    pending_q.push_back(typed ? typed_exp : twirl_source(x, y));
    items_sent++;
    if (items_sent == 350) begin
      tx_idle_pct = 71;
      rx_idle_pct = 20;
    end else if (items_sent == 700) begin
      tx_idle_pct = 0;
      rx_idle_pct = 0;
    end
  endtask

  // sender pauses until every expected result is back
  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic random_phase(int n);
    logic [11:0] x, y;
    int pick;
    for (int k = 0; k < n; k++) begin
      pick = $urandom_range(9);
      if (pick < 3 || img_w == 0 || img_h == 0) begin
        x = 12'($urandom_range(4095));
        y = 12'($urandom_range(4095));
      end else if (pick == 3) begin
        // near the centre, axis and zero-phase cases
        x = 12'((img_w >> 1) + $urandom_range(4) - 2);
        y = 12'((img_h >> 1) + $urandom_range(4) - 2);
      end else begin
        x = 12'($urandom_range(img_w - 1));
        y = 12'($urandom_range(img_h - 1));
      end
      send_pixel(x, y, 1'b0, '0);
    end
    drain();
  endtask

  // receiver: random stalls plus one long hold so the pipeline backs up
  initial begin
    int hold_left;
    bit held;
    hold_left = 0;
    held = 1'b0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!held && results_seen >= HOLD_AT) begin
        held = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready = 1'b0;
      end else begin
        out_ready = ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // result check against the oldest expectation
  always @(posedge clk) begin
    remap_t got, want;
    if (rst_n && out_valid && out_ready) begin
      got = '{out_dest_x, out_dest_y, out_src_x, out_src_y, out_in_range};
      results_seen++;
      if (pending_q.size() == 0) begin
        $display("%0t unexpected item: dest %0d,%0d src %0d,%0d in_range %0d", $time,
                 got.dest_x, got.dest_y, got.src_x, got.src_y, got.in_range);
        errors++;
      end else begin
        want = pending_q.pop_front();
        if (got !== want) begin
          $display("%0t mismatch: exp dest %0d,%0d src %0d,%0d in_range %0d", $time,
                   want.dest_x, want.dest_y, want.src_x, want.src_y, want.in_range);
          $display("%0t          got dest %0d,%0d src %0d,%0d in_range %0d", $time,
                   got.dest_x, got.dest_y, got.src_x, got.src_y, got.in_range);
          errors++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > RUN_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    logic [11:0] w_rnd;
    errors = 0;
    cycles = 0;
    items_sent = 0;
    results_seen = 0;
    tx_idle_pct = 20;
    rx_idle_pct = 71;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_out_x = '0;
    in_out_y = '0;
    cfg_we = 1'b0;
    cfg_index = CFG_WIDTH;
    cfg_data = '0;
    img_w = 12'd640;
    img_h = 12'd480;
    ang_scale = 28'd41963946;
    rad_scale = 18'd78643;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed part on the reset registers
    foreach (dir_rows[i])
      send_pixel(dir_rows[i].x, dir_rows[i].y, dir_rows[i].typed, dir_rows[i].exp);
    drain();

    // largest image size and angle scale
    wr_cfg(CFG_WIDTH, 28'd4095);
    wr_cfg(CFG_HEIGHT, 28'd4095);
    wr_cfg(CFG_ANGLE, 28'hFFF_FFFF);
    wr_cfg(CFG_RADIUS, 28'd131072);
    random_phase(PHASE_ITEMS);

    // smallest nonzero image, zero scales
    wr_cfg(CFG_WIDTH, 28'd1);
    wr_cfg(CFG_HEIGHT, 28'd1);
    wr_cfg(CFG_ANGLE, 28'd0);
    wr_cfg(CFG_RADIUS, 28'd0);
    random_phase(PHASE_ITEMS);

    // zero size image: every result black
    wr_cfg(CFG_WIDTH, 28'd0);
    wr_cfg(CFG_HEIGHT, 28'd0);
    wr_cfg(CFG_ANGLE, 28'($urandom_range(28'hFFF_FFFF)));
    wr_cfg(CFG_RADIUS, 28'($urandom_range(131072)));
    random_phase(PHASE_ITEMS / 2);

    // random image, angle scale 10430 times the width
    w_rnd = 12'($urandom_range(4095, 16));
    wr_cfg(CFG_WIDTH, 28'(w_rnd));
    wr_cfg(CFG_HEIGHT, 28'($urandom_range(4095, 16)));
    wr_cfg(CFG_ANGLE, 28'(w_rnd) * 28'd10430);
    wr_cfg(CFG_RADIUS, 28'($urandom_range(131072)));
    random_phase(PHASE_ITEMS);

    // fully random registers
    wr_cfg(CFG_WIDTH, 28'($urandom_range(4095, 1)));
    wr_cfg(CFG_HEIGHT, 28'($urandom_range(4095, 1)));
    wr_cfg(CFG_ANGLE, 28'($urandom_range(28'hFFF_FFFF)));
    wr_cfg(CFG_RADIUS, 28'($urandom_range(131072)));
    random_phase(PHASE_ITEMS);

    // back to the default image, with a write to an unused index in between
    wr_cfg(CFG_WIDTH, 28'd640);
    wr_cfg(CFG_HEIGHT, 28'd480);
    wr_cfg(CFG_UNUSED, 28'hABC_DEF1);
    wr_cfg(CFG_ANGLE, 28'd41963946);
    wr_cfg(CFG_RADIUS, 28'd78643);
    random_phase(PHASE_ITEMS + PHASE_ITEMS / 2);

    if (errors == 0 && pending_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

### filelist.f
design/ptsa_pkg.sv
design/polar_twirl_source_address.sv
design/ptsa_checker.sv
tb/polar_twirl_source_address_tb.sv
